>>> rtl/core/sha_pkg.sv
// Package: shared types, constants and round functions for the SHA-256 core.
package sha_pkg;

  localparam logic [31:0] PadWord = 32'h8000_0000;

  typedef logic [31:0] word_t;

  // Word queued between front and back part.
  typedef struct packed {
    logic [31:0] data;
    logic        block_end;  // this word fills slot 15
    logic        msg_end;    // block closes the message, emit digest after
  } slot_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_ADD,
    BK_OUT
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_TAKE,
    FR_PAD,
    FR_LEN_HI,
    FR_LEN_LO
  } fr_state_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/core/sha_if.sv
// Interfaces: input word channel and digest channel.
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        message_end;
  modport source (output valid, data_word, byte_count, message_end, input ready);
  modport sink (input valid, data_word, byte_count, message_end, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;
  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

>>> rtl/core/sha_front.sv
// Front part: takes input beats, counts length, inserts padding and length words.
module sha_front (
  input  logic           clk,
  input  logic           rst_n,
  sha_in_if.sink         in_ch,
  output sha_pkg::slot_t slot,
  output logic           slot_valid,
  input  logic           slot_ready
);

  sha_pkg::fr_state_t state_r, state_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [2:0]  cnt;
  logic [31:0] keep;
  logic [31:0] tail;
  logic        push;
  // first padding word after a full final word holds the 0x80 byte
  logic        pad_first_r;

  always_comb begin
    if (!in_ch.message_end || in_ch.byte_count > 3'd4) cnt = 3'd4;
    else cnt = in_ch.byte_count;
    case (cnt)
      3'd0: keep = 32'h0;
      3'd1: keep = 32'hff00_0000;
      3'd2: keep = 32'hffff_0000;
      3'd3: keep = 32'hffff_ff00;
      default: keep = 32'hffff_ffff;
    endcase
    tail = (in_ch.data_word & keep) | (sha_pkg::PadWord >> {cnt[1:0], 3'b000});
  end

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    in_ch.ready = 1'b0;
    slot_valid  = 1'b0;
    slot.data   = 32'h0;
    slot.msg_end = 1'b0;
    case (state_r)
      sha_pkg::FR_TAKE: begin
        in_ch.ready = slot_ready;
        slot_valid  = in_ch.valid;
        if (in_ch.message_end && cnt != 3'd4) slot.data = tail;
        else slot.data = in_ch.data_word;
        if (in_ch.valid && slot_ready) begin
          len_nxt = len_r + {58'd0, cnt, 3'b000};
          if (in_ch.message_end) begin
            if (cnt == 3'd4) state_nxt = sha_pkg::FR_PAD;
            else if (pos_r == 4'd13) state_nxt = sha_pkg::FR_LEN_HI;
            else state_nxt = sha_pkg::FR_PAD;
          end
        end
      end
      sha_pkg::FR_PAD: begin
        // after a full final word the first pad word carries 0x80
        slot_valid = 1'b1;
        slot.data  = pad_first_r ? sha_pkg::PadWord : 32'h0;
        if (slot_ready && pos_r == 4'd13) state_nxt = sha_pkg::FR_LEN_HI;
      end
      sha_pkg::FR_LEN_HI: begin
        slot_valid = 1'b1;
        slot.data  = len_r[63:32];
        if (slot_ready) state_nxt = sha_pkg::FR_LEN_LO;
      end
      default: begin
        slot_valid   = 1'b1;
        slot.data    = len_r[31:0];
        slot.msg_end = 1'b1;
        if (slot_ready) begin
          state_nxt = sha_pkg::FR_TAKE;
          len_nxt   = 64'd0;
        end
      end
    endcase
    push = slot_valid && slot_ready;
    if (push) pos_nxt = pos_r + 4'd1;
    slot.block_end = (pos_r == 4'd15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_first_r <= 1'b0;
    end else if (state_r == sha_pkg::FR_TAKE) begin
      pad_first_r <= in_ch.message_end && cnt == 3'd4;
    end else if (push) begin
      pad_first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::FR_TAKE;
      len_r   <= 64'd0;
      pos_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

  a_len_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::FR_LEN_HI) |-> (pos_r == 4'd14))
    else $error("length word out of place");
  a_pad_range: assert property (@(posedge clk) disable iff (!rst_n)
    (slot.msg_end && slot_valid) |-> (pos_r == 4'd15))
    else $error("message end not at block end");
  a_ready_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == sha_pkg::FR_TAKE))
    else $error("input taken while padding");

endmodule

>>> rtl/core/sha_fifo.sv
// Short queue of schedule words between front and back part.
module sha_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  sha_pkg::slot_t wr_slot,
  input  logic           wr_valid,
  output logic           wr_ready,
  output sha_pkg::slot_t rd_slot,
  output logic           rd_valid,
  input  logic           rd_ready
);

  sha_pkg::slot_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign rd_slot  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 2'd0; rp_r <= 2'd0; cnt_r <= 3'd0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr} - {2'd0, rd};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("queue count overflow");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 || cnt_r == 3'd4) |-> (wp_r == rp_r))
    else $error("queue pointers disagree");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid && !rd_ready && !wr) |=> rd_valid)
    else $error("queue lost a word");

endmodule

>>> rtl/core/sha_back.sv
// Back part: schedule window, 64 compression rounds, hash update, digest out.
module sha_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sha_pkg::slot_t slot,
  input  logic           slot_valid,
  output logic           slot_ready,
  sha_out_if.source      out_ch
);

  sha_pkg::bk_state_t state_r, state_nxt;
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [3:0]  pos_r;
  logic [5:0]  rnd_r;
  logic [2:0]  oi_r;
  logic        fin_r;
  logic [31:0] w2, w15, sg0, sg1, wt, s1, ch, t1, s0, mj;

  always_comb begin
    w2  = w_r[rnd_r[3:0] - 4'd2];
    w15 = w_r[rnd_r[3:0] - 4'd15];
    sg1 = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
    sg0 = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
    if (rnd_r < 6'd16) wt = w_r[rnd_r[3:0]];
    else wt = sg1 + w_r[rnd_r[3:0] - 4'd7] + sg0 + w_r[rnd_r[3:0]];
    s1 = sha_pkg::rotr(v_r[4], 6) ^ sha_pkg::rotr(v_r[4], 11) ^ sha_pkg::rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + sha_pkg::round_k(rnd_r) + wt;
    s0 = sha_pkg::rotr(v_r[0], 2) ^ sha_pkg::rotr(v_r[0], 13) ^ sha_pkg::rotr(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  always_comb begin
    state_nxt  = state_r;
    slot_ready = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      sha_pkg::BK_IDLE: begin
        slot_ready = 1'b1;
        if (slot_valid && slot.block_end) state_nxt = sha_pkg::BK_ROUND;
      end
      sha_pkg::BK_ROUND: if (rnd_r == 6'd63) state_nxt = sha_pkg::BK_ADD;
      sha_pkg::BK_ADD: state_nxt = fin_r ? sha_pkg::BK_OUT : sha_pkg::BK_IDLE;
      default: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready && oi_r == 3'd7) state_nxt = sha_pkg::BK_IDLE;
      end
    endcase
  end

  assign out_ch.digest_word = h_r[oi_r];
  assign out_ch.word_index  = oi_r;
  assign out_ch.digest_last = (oi_r == 3'd7);

  always_ff @(posedge clk) begin
    if (state_r == sha_pkg::BK_IDLE && slot_valid) w_r[pos_r] <= slot.data;
    if (state_r == sha_pkg::BK_ROUND && rnd_r >= 6'd16) w_r[rnd_r[3:0]] <= wt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::BK_IDLE;
      pos_r <= 4'd0; rnd_r <= 6'd0; oi_r <= 3'd0; fin_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= sha_pkg::init_hash(3'(i));
        v_r[i] <= 32'd0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        sha_pkg::BK_IDLE: if (slot_valid) begin
          pos_r <= pos_r + 4'd1;
          if (slot.block_end) begin
            fin_r <= slot.msg_end;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          end
        end
        sha_pkg::BK_ROUND: begin
          rnd_r  <= rnd_r + 6'd1;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + s0 + mj;
        end
        sha_pkg::BK_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        end
        default: if (out_ch.ready) begin
          oi_r <= oi_r + 3'd1;
          if (oi_r == 3'd7) begin
            for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_hash(3'(i));
          end
        end
      endcase
    end
  end

  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sha_pkg::BK_ROUND) |-> (rnd_r == 6'd0))
    else $error("round counter not cleared");
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::BK_ROUND) |-> (pos_r == 4'd0))
    else $error("block slot count off");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !slot_ready)
    else $error("words taken during digest");

endmodule

>>> rtl/core/sha256_hash_core_top.sv
// Top level of the SHA-256 hash core.
// SHA-256 core. Message words arrive as beats on in_ch (big-endian, byte count
// meaningful only on the end beat); the digest leaves as eight beats on out_ch,
// word 0 first, digest_last on word 7. The front part counts the bit length and
// adds the 0x80 byte, zero words and the 64-bit length, with an extra block when
// the length does not fit; a four-deep queue feeds the back part. Each 16-word
// block is taken in word by word, then runs its compression rounds and the hash
// update in the single round unit, which takes no new words until the block and
// any digest output are done. Up to four input beats queue up while rounds run.
module sha256_hash_core_top (
  input logic    clk,
  input logic    rst_n,
  sha_in_if.sink   in_ch,
  sha_out_if.source out_ch
);

  sha_pkg::slot_t f_slot, b_slot;
  logic f_valid, f_ready, b_valid, b_ready;

  sha_front u_front (
    .clk, .rst_n, .in_ch,
    .slot(f_slot), .slot_valid(f_valid), .slot_ready(f_ready)
  );

  sha_fifo u_fifo (
    .clk, .rst_n,
    .wr_slot(f_slot), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_slot(b_slot), .rd_valid(b_valid), .rd_ready(b_ready)
  );

  sha_back u_back (
    .clk, .rst_n,
    .slot(b_slot), .slot_valid(b_valid), .slot_ready(b_ready), .out_ch
  );

endmodule
